@@ hdl/ray_intersection_setup_unit_assert.svh @@
// Assertion macros shared by the ray setup unit.
`ifndef RAY_INTERSECTION_SETUP_UNIT_ASSERT_SVH
`define RAY_INTERSECTION_SETUP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RISU_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("ray setup assertion failed");

// Next-cycle implication, checked outside reset.
`define RISU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("ray setup assertion failed");

`endif

@@ hdl/risu_pkg.sv @@
package risu_pkg;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] EXP_ALL   = 32'h7F80_0000;
    localparam logic [31:0] NAN_CANON = 32'h7FC0_0000;
    localparam logic [31:0] ONE_F     = 32'h3F80_0000;
    localparam logic [31:0] CLAMP_EPS = 32'h3727_C5AC;  // 1e-5 in single precision

    localparam logic signed [9:0] EXP_BIAS = 10'sd127;

    // Divider: restoring, two quotient bits per pipeline stage.
    localparam int QUO_BITS       = 28;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;
    localparam int DIV_LAT        = DIV_STAGES + 3;
    localparam int MUL_LAT        = 4;
    localparam int PIPE_LAT       = 1 + DIV_LAT + MUL_LAT;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        FC_NUM,
        FC_ZERO,
        FC_INF,
        FC_NAN
    } fcls_t;

    // Unpacked operand: mantissa normalized with its leading one at bit 23.
    typedef struct packed {
        logic               sign;
        fcls_t              cls;
        logic signed [9:0]  exp;
        logic [23:0]        mant;
    } funp_t;

    // Value ahead of rounding: biased exponent, normalized mantissa, guard, sticky.
    typedef struct packed {
        logic               sign;
        fcls_t              cls;
        logic signed [9:0]  exp;
        logic [23:0]        mant;
        logic               grd;
        logic               stk;
    } fpre_t;

    typedef struct packed {
        logic [31:0] dir_x;
        logic [31:0] dir_y;
        logic [31:0] dir_z;
        logic [31:0] org_x;
        logic [31:0] org_y;
        logic [31:0] org_z;
    } ray_t;

    typedef struct packed {
        axis_t       axis_local_x;
        axis_t       axis_major;
        axis_t       axis_local_z;
        logic [31:0] shear_x;
        logic [31:0] shear_y;
        logic [31:0] shear_z;
        logic [31:0] inv_dir_x;
        logic [31:0] inv_dir_y;
        logic [31:0] inv_dir_z;
        logic [31:0] slab_off_x;
        logic [31:0] slab_off_y;
        logic [31:0] slab_off_z;
    } res_t;

    function automatic axis_t axis_next(input axis_t a);
        axis_t n;
        case (a)
            AXIS_X:  n = AXIS_Y;
            AXIS_Y:  n = AXIS_Z;
            default: n = AXIS_X;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] m);
        logic [4:0] lz;
        lz = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) lz = 5'(23 - i);
        end
        return lz;
    endfunction

    function automatic funp_t f_unpack(input logic [31:0] v);
        funp_t      u;
        logic [23:0] m;
        logic [4:0]  lz;
        u.sign = v[31];
        m      = {1'b0, v[22:0]};
        lz     = lzc24(m);
        if (v[30:23] == 8'hFF) begin
            u.cls = (v[22:0] != 23'd0) ? FC_NAN : FC_INF;
        end else if (v[30:0] == 31'd0) begin
            u.cls = FC_ZERO;
        end else begin
            u.cls = FC_NUM;
        end
        if (v[30:23] == 8'd0) begin
            u.mant = m << lz;
            u.exp  = 10'sd1 - $signed({5'b0, lz});
        end else begin
            u.mant = {1'b1, v[22:0]};
            u.exp  = $signed({2'b0, v[30:23]});
        end
        return u;
    endfunction

endpackage

@@ hdl/risu_stream_if.sv @@
interface risu_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/risu_fround.sv @@
// Two-stage rounding: denormalizing shift, then round to nearest even and pack.
module risu_fround import risu_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  fpre_t       pre,
    output logic [31:0] result
);

    logic              sign_reg;
    fcls_t             cls_reg;
    logic              ovf_reg;
    logic [7:0]        expf_reg;
    logic [22:0]       frac_reg;
    logic              grd_reg;
    logic              stk_reg;
    logic [31:0]       result_reg;

    logic              ovf_next;
    logic [7:0]        expf_next;
    logic [22:0]       frac_next;
    logic              grd_next;
    logic              stk_next;
    logic [31:0]       result_next;

    logic signed [9:0] ushift;
    logic [4:0]        sh;
    logic [51:0]       wide;
    logic              inc;
    logic [30:0]       sum;

    always_comb
    begin
        ovf_next = (pre.exp > 10'sd254);
        ushift   = 10'sd1 - pre.exp;
        if (pre.exp > 10'sd0)
        begin
            sh        = 5'd0;
            expf_next = pre.exp[7:0];
        end
        else
        begin
            sh        = (ushift > 10'sd31) ? 5'd31 : ushift[4:0];
            expf_next = 8'd0;
        end
        wide      = {pre.mant, pre.grd, pre.stk, 26'b0} >> sh;
        frac_next = wide[50:28];
        grd_next  = wide[27];
        stk_next  = |wide[26:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg <= pre.sign;
            cls_reg  <= pre.cls;
            ovf_reg  <= ovf_next;
            expf_reg <= expf_next;
            frac_reg <= frac_next;
            grd_reg  <= grd_next;
            stk_reg  <= stk_next;
        end
    end

    always_comb
    begin
        inc = grd_reg & (stk_reg | frac_reg[0]);
        sum = {expf_reg, frac_reg} + {30'b0, inc};
        case (cls_reg)
            FC_NAN:  result_next = NAN_CANON;
            FC_INF:  result_next = {sign_reg, EXP_ALL[30:0]};
            FC_ZERO: result_next = {sign_reg, 31'b0};
            default:
            begin
                if (ovf_reg || sum[30:23] == 8'hFF)
                    result_next = {sign_reg, EXP_ALL[30:0]};
                else
                    result_next = {sign_reg, sum};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

@@ hdl/risu_fdiv.sv @@
// Pipelined single-precision divider: unpack, restoring quotient stages, round.
module risu_fdiv import risu_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);

    typedef struct packed {
        logic                  sign;
        fcls_t                 cls;
        logic signed [9:0]     exp;
        logic [24:0]           rem;
        logic [23:0]           dm;
        logic [QUO_BITS-1:0]   q;
    } dstage_t;

    funp_t   ua;
    funp_t   ub;
    dstage_t st_next [DIV_STAGES+1];
    dstage_t st_reg  [DIV_STAGES+1];
    dstage_t fin;
    fpre_t   pre;

    always_comb
    begin
        logic [24:0]         r;
        logic [25:0]         diff;
        logic [QUO_BITS-1:0] qb;
        ua = f_unpack(num);
        ub = f_unpack(den);
        st_next[0].sign = ua.sign ^ ub.sign;
        if (ua.cls == FC_NAN || ub.cls == FC_NAN ||
            (ua.cls == FC_INF && ub.cls == FC_INF) ||
            (ua.cls == FC_ZERO && ub.cls == FC_ZERO))
            st_next[0].cls = FC_NAN;
        else if (ua.cls == FC_INF || ub.cls == FC_ZERO)
            st_next[0].cls = FC_INF;
        else if (ua.cls == FC_ZERO || ub.cls == FC_INF)
            st_next[0].cls = FC_ZERO;
        else
            st_next[0].cls = FC_NUM;
        st_next[0].exp = ua.exp - ub.exp + EXP_BIAS;
        st_next[0].rem = {1'b0, ua.mant};
        st_next[0].dm  = ub.mant;
        st_next[0].q   = '0;

        // Each stage retires its quotient bits from the previous stage's remainder.
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            st_next[k] = st_reg[k-1];
            r  = st_reg[k-1].rem;
            qb = st_reg[k-1].q;
            for (int b = 0; b < BITS_PER_STAGE; b++)
            begin
                diff = {1'b0, r} - {2'b0, st_reg[k-1].dm};
                qb   = {qb[QUO_BITS-2:0], ~diff[25]};
                if (!diff[25])
                    r = {diff[23:0], 1'b0};
                else
                    r = {r[23:0], 1'b0};
            end
            st_next[k].rem = r;
            st_next[k].q   = qb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    always_comb
    begin
        fin      = st_reg[DIV_STAGES];
        pre.sign = fin.sign;
        pre.cls  = fin.cls;
        if (fin.q[QUO_BITS-1])
        begin
            pre.exp  = fin.exp;
            pre.mant = fin.q[QUO_BITS-1:QUO_BITS-24];
            pre.grd  = fin.q[QUO_BITS-25];
            pre.stk  = (|fin.q[QUO_BITS-26:0]) | (|fin.rem);
        end
        else
        begin
            pre.exp  = fin.exp - 10'sd1;
            pre.mant = fin.q[QUO_BITS-2:QUO_BITS-25];
            pre.grd  = fin.q[QUO_BITS-26];
            pre.stk  = (|fin.q[QUO_BITS-27:0]) | (|fin.rem);
        end
    end

    risu_fround u_round
    (
        .clk    (clk),
        .en     (en),
        .pre    (pre),
        .result (quo)
    );

endmodule

@@ hdl/risu_fmul.sv @@
// Pipelined single-precision multiplier: unpack, 24x24 product, round.
module risu_fmul import risu_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] prod
);

    funp_t             ua;
    funp_t             ub;
    logic              sign0_reg;
    fcls_t             cls0_reg;
    logic signed [9:0] exp0_reg;
    logic [23:0]       ma_reg;
    logic [23:0]       mb_reg;
    fcls_t             cls0_next;
    logic signed [9:0] exp0_next;

    logic              sign1_reg;
    fcls_t             cls1_reg;
    logic signed [9:0] exp1_reg;
    logic [47:0]       p_reg;
    logic [47:0]       p_next;
    fpre_t             pre;

    always_comb
    begin
        ua = f_unpack(a);
        ub = f_unpack(b);
        if (ua.cls == FC_NAN || ub.cls == FC_NAN ||
            (ua.cls == FC_INF && ub.cls == FC_ZERO) ||
            (ua.cls == FC_ZERO && ub.cls == FC_INF))
            cls0_next = FC_NAN;
        else if (ua.cls == FC_INF || ub.cls == FC_INF)
            cls0_next = FC_INF;
        else if (ua.cls == FC_ZERO || ub.cls == FC_ZERO)
            cls0_next = FC_ZERO;
        else
            cls0_next = FC_NUM;
        exp0_next = ua.exp + ub.exp - EXP_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign0_reg <= ua.sign ^ ub.sign;
            cls0_reg  <= cls0_next;
            exp0_reg  <= exp0_next;
            ma_reg    <= ua.mant;
            mb_reg    <= ub.mant;
        end
    end

    assign p_next = {24'b0, ma_reg} * {24'b0, mb_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign1_reg <= sign0_reg;
            cls1_reg  <= cls0_reg;
            exp1_reg  <= exp0_reg;
            p_reg     <= p_next;
        end
    end

    always_comb
    begin
        pre.sign = sign1_reg;
        pre.cls  = cls1_reg;
        if (p_reg[47])
        begin
            pre.exp  = exp1_reg + 10'sd1;
            pre.mant = p_reg[47:24];
            pre.grd  = p_reg[23];
            pre.stk  = |p_reg[22:0];
        end
        else
        begin
            pre.exp  = exp1_reg;
            pre.mant = p_reg[46:23];
            pre.grd  = p_reg[22];
            pre.stk  = |p_reg[21:0];
        end
    end

    risu_fround u_round
    (
        .clk    (clk),
        .en     (en),
        .pre    (pre),
        .result (prod)
    );

endmodule

@@ hdl/ray_intersection_setup_unit.sv @@
// Channel | Dir | Word  | Contents
// ray     | in  | ray_t | ray direction and origin, single precision bit patterns
// res     | out | res_t | axis frame, shear factors, slab reciprocals and offsets
//
// One ray word is taken every clock while ray.ready is high; the path is a
// 22-stage pipeline between the ray input and the output buffer.
// The depth comes from the restoring dividers (two quotient bits per stage)
// followed by the slab-offset multipliers, all running in lockstep.
// A two-word output buffer sits behind the pipeline: ray.ready drops only when
// both buffer entries wait on the consumer, and then the whole pipeline holds.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits and the buffer.
`include "ray_intersection_setup_unit_assert.svh"

module ray_intersection_setup_unit import risu_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    risu_stream_if.sink   ray,
    risu_stream_if.source res
);

    // First stage: major axis choice, permutation and clamping.
    typedef struct packed {
        axis_t       lx;
        axis_t       ly;
        axis_t       lz;
        logic [31:0] nsx;
        logic [31:0] nsz;
        logic [31:0] dly;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] nox;
        logic [31:0] noy;
        logic [31:0] noz;
    } stga_t;

    typedef struct packed {
        axis_t lx;
        axis_t ly;
        axis_t lz;
    } axes_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vec3_t;

    typedef struct packed {
        vec3_t shear;
        vec3_t inv;
    } divout_t;

    ray_t                 rin;
    stga_t                a_next;
    stga_t                a_reg;
    logic [PIPE_LAT-1:0]  vld_reg;
    logic                 adv;

    axes_t                ax_dly_reg  [DIV_LAT+MUL_LAT];
    vec3_t                org_dly_reg [DIV_LAT];
    divout_t              dv_dly_reg  [MUL_LAT];

    divout_t              dv;
    vec3_t                off;
    res_t                 fin;

    res_t                 fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   cnt_reg;
    logic [FIFO_CW-1:0]   cnt_next;
    logic                 push;
    logic                 pop;

    // A compare with a NaN is false, as in float arithmetic.
    function automatic logic mag_gt(input logic [31:0] p, input logic [31:0] q);
        return (p[30:0] <= EXP_ALL[30:0]) && (q[30:0] <= EXP_ALL[30:0]) &&
               (p[30:0] > q[30:0]);
    endfunction

    function automatic logic [31:0] sel_axis(input ray_t r, input axis_t ax);
        logic [31:0] v;
        case (ax)
            AXIS_X:  v = r.dir_x;
            AXIS_Y:  v = r.dir_y;
            default: v = r.dir_z;
        endcase
        return v;
    endfunction

    // Tiny components become +-1e-5; negative zero goes to the positive side.
    function automatic logic [31:0] clamp_dir(input logic [31:0] d);
        logic [31:0] c;
        if (d[30:0] < CLAMP_EPS[30:0])
            c = (d[31] && d[30:0] != 31'd0) ? (CLAMP_EPS | SIGN_BIT) : CLAMP_EPS;
        else
            c = d;
        return c;
    endfunction

    assign rin = ray.data;

    // The whole pipeline moves together whenever the output buffer has room.
    assign adv       = (cnt_reg != FIFO_CW'(FIFO_DEPTH));
    assign ray.ready = adv;

    always_comb
    begin
        if (mag_gt(rin.dir_x, rin.dir_y) && mag_gt(rin.dir_x, rin.dir_z))
            a_next.ly = AXIS_X;
        else if (mag_gt(rin.dir_y, rin.dir_z))
            a_next.ly = AXIS_Y;
        else
            a_next.ly = AXIS_Z;
        a_next.lz  = axis_next(a_next.ly);
        a_next.lx  = axis_next(a_next.lz);
        a_next.nsx = sel_axis(rin, a_next.lx) ^ SIGN_BIT;
        a_next.nsz = sel_axis(rin, a_next.lz) ^ SIGN_BIT;
        a_next.dly = sel_axis(rin, a_next.ly);
        a_next.cx  = clamp_dir(rin.dir_x);
        a_next.cy  = clamp_dir(rin.dir_y);
        a_next.cz  = clamp_dir(rin.dir_z);
        a_next.nox = rin.org_x ^ SIGN_BIT;
        a_next.noy = rin.org_y ^ SIGN_BIT;
        a_next.noz = rin.org_z ^ SIGN_BIT;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            a_reg <= a_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], ray.valid};
    end

    // Side data rides along in shift lines that match the arithmetic depth.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_dly_reg[0]  <= '{lx: a_reg.lx, ly: a_reg.ly, lz: a_reg.lz};
            for (int k = 1; k < DIV_LAT + MUL_LAT; k++)
                ax_dly_reg[k] <= ax_dly_reg[k-1];
            org_dly_reg[0] <= '{x: a_reg.nox, y: a_reg.noy, z: a_reg.noz};
            for (int k = 1; k < DIV_LAT; k++)
                org_dly_reg[k] <= org_dly_reg[k-1];
            dv_dly_reg[0]  <= dv;
            for (int k = 1; k < MUL_LAT; k++)
                dv_dly_reg[k] <= dv_dly_reg[k-1];
        end
    end

    risu_fdiv u_div_sx (.clk(clk), .en(adv), .num(a_reg.nsx), .den(a_reg.dly), .quo(dv.shear.x));
    risu_fdiv u_div_sy (.clk(clk), .en(adv), .num(ONE_F),     .den(a_reg.dly), .quo(dv.shear.y));
    risu_fdiv u_div_sz (.clk(clk), .en(adv), .num(a_reg.nsz), .den(a_reg.dly), .quo(dv.shear.z));
    risu_fdiv u_div_ix (.clk(clk), .en(adv), .num(ONE_F),     .den(a_reg.cx),  .quo(dv.inv.x));
    risu_fdiv u_div_iy (.clk(clk), .en(adv), .num(ONE_F),     .den(a_reg.cy),  .quo(dv.inv.y));
    risu_fdiv u_div_iz (.clk(clk), .en(adv), .num(ONE_F),     .den(a_reg.cz),  .quo(dv.inv.z));

    risu_fmul u_mul_x (.clk(clk), .en(adv), .a(org_dly_reg[DIV_LAT-1].x), .b(dv.inv.x),
                       .prod(off.x));
    risu_fmul u_mul_y (.clk(clk), .en(adv), .a(org_dly_reg[DIV_LAT-1].y), .b(dv.inv.y),
                       .prod(off.y));
    risu_fmul u_mul_z (.clk(clk), .en(adv), .a(org_dly_reg[DIV_LAT-1].z), .b(dv.inv.z),
                       .prod(off.z));

    always_comb
    begin
        fin.axis_local_x = ax_dly_reg[DIV_LAT+MUL_LAT-1].lx;
        fin.axis_major   = ax_dly_reg[DIV_LAT+MUL_LAT-1].ly;
        fin.axis_local_z = ax_dly_reg[DIV_LAT+MUL_LAT-1].lz;
        fin.shear_x      = dv_dly_reg[MUL_LAT-1].shear.x;
        fin.shear_y      = dv_dly_reg[MUL_LAT-1].shear.y;
        fin.shear_z      = dv_dly_reg[MUL_LAT-1].shear.z;
        fin.inv_dir_x    = dv_dly_reg[MUL_LAT-1].inv.x;
        fin.inv_dir_y    = dv_dly_reg[MUL_LAT-1].inv.y;
        fin.inv_dir_z    = dv_dly_reg[MUL_LAT-1].inv.z;
        fin.slab_off_x   = off.x;
        fin.slab_off_y   = off.y;
        fin.slab_off_z   = off.z;
    end

    // Output buffer: decouples the pipeline from the consumer's ready.
    assign push = vld_reg[PIPE_LAT-1] && adv;
    assign pop  = res.valid && res.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + FIFO_CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= fin;
    end

    assign res.valid = (cnt_reg != '0);
    assign res.data  = fifo_reg[rd_ptr_reg];

    `RISU_ASSERT_IMPLY(a_fifo_bound, clk, rst_n, 1'b1, cnt_reg <= FIFO_CW'(FIFO_DEPTH))
    `RISU_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(vld_reg))
    `RISU_ASSERT_NEXT(a_push_count, clk, rst_n, push && !pop, cnt_reg != '0)
    `RISU_ASSERT_IMPLY(a_axis_frame, clk, rst_n, res.valid, (res.data.axis_local_z == axis_next(res.data.axis_major)) && (res.data.axis_local_x == axis_next(res.data.axis_local_z)))
    `RISU_ASSERT_IMPLY(a_nan_canon, clk, rst_n, res.valid && (res.data.shear_y[30:0] > EXP_ALL[30:0]), res.data.shear_y == NAN_CANON)

endmodule
